[hdl/piecewise_linear_waveform_gen_top_assert.svh]
// Assertion macros used by the waveform generator datapath
`ifndef PIECEWISE_LINEAR_WAVEFORM_GEN_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_WAVEFORM_GEN_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PLWG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plwg assertion failed");

// Next-cycle implication, checked out of reset
`define PLWG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plwg assertion failed");

`endif

[hdl/plwg_pkg.sv]
`timescale 1ns / 1ps
package plwg_pkg;

  localparam int MaxPoints = 64;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int PtrW      = AddrW + 1;
  localparam int RndW      = 21;
  localparam int CfgDataW  = 21;
  localparam int DvdW      = 48;
  localparam int DsrW      = 33;
  localparam int SlopeW    = 48;

  // Request kinds
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  // Configuration register indexes
  localparam logic CfgRounding  = 1'b0;
  localparam logic CfgNumPoints = 1'b1;

  // Result status codes
  localparam logic [1:0] StQueryOk = 2'd0;
  localparam logic [1:0] StStored  = 2'd1;
  localparam logic [1:0] StZeroSeg = 2'd2;
  localparam logic [1:0] StReject  = 2'd3;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_sel;
    logic rnd_mul;
    logic rnd_fin;
    logic rd_prev;
    logic ld_commit;
    logic clamp_ptr;
    logic rd_ptr;
    logic ptr_inc;
    logic rd_k;
    logic mul_init;
    logic mul_step;
    logic q_fin;
    logic set_reject;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic req;
    logic ld_ok;
    logic q_ok;
    logic ptr_lt_n;
    logic time_lt;
    logic ptr_mid;
    logic dt_zero;
    logic p_zero;
    logic div_busy;
    logic mul_last;
    logic out_free;
  } sts_t;

endpackage

[hdl/plwg_if.sv]
`timescale 1ns / 1ps
interface plwg_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [5:0]         point_index;
  logic signed [31:0] time_us;
  logic signed [31:0] amplitude;
  modport source (output valid, req_type, point_index, time_us, amplitude, input ready);
  modport sink   (input valid, req_type, point_index, time_us, amplitude, output ready);
endinterface

interface plwg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [6:0]         segment;
  logic [1:0]         status;
  modport source (output valid, value, segment, status, input ready);
  modport sink   (input valid, value, segment, status, output ready);
endinterface

[hdl/plwg_div.sv]
`timescale 1ns / 1ps
module plwg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [plwg_pkg::DvdW-1:0]   dividend_i,
  input  logic [plwg_pkg::DsrW-1:0]   divisor_i,
  output logic                        busy_o,
  output logic [plwg_pkg::DvdW-1:0]   quo_o
);
  import plwg_pkg::*;

  localparam int CntW = $clog2(DvdW);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] quo_q;
  logic [DsrW-1:0] rem_q;
  logic [DsrW-1:0] dsr_q;
  logic [DsrW:0]   trial;
  logic            fits;

  // Restoring step: shift in one dividend bit, subtract when it fits
  assign trial = {rem_q, quo_q[DvdW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  // Control: one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(DvdW - 1)) busy_q <= 1'b0;
    end
  end

  // Datapath of the shared divider
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DvdW-2:0], fits};
      rem_q <= fits ? DsrW'(trial - {1'b0, dsr_q}) : trial[DsrW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

[hdl/plwg_dp.sv]
`timescale 1ns / 1ps
`include "piecewise_linear_waveform_gen_top_assert.svh"
module plwg_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_req_type_i,
  input  logic [5:0]                    in_point_index_i,
  input  logic signed [31:0]            in_time_us_i,
  input  logic signed [31:0]            in_amplitude_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [plwg_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          out_ready_i,
  input  plwg_pkg::cmd_t                cmd_i,
  output plwg_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  output logic signed [31:0]            out_value_o,
  output logic [6:0]                    out_segment_o,
  output logic [1:0]                    out_status_o
);
  import plwg_pkg::*;

  logic [RndW-1:0]   rounding_q;
  logic [PtrW-1:0]   num_points_q;
  logic [PtrW-1:0]   n_eff;
  logic              req_q;
  logic [AddrW-1:0]  p_q;
  logic signed [31:0] t_q;
  logic signed [31:0] amp_q;
  logic [PtrW-1:0]   seg_ptr_q;
  logic [PtrW-1:0]   loaded_q;
  logic [31:0]       tm_rd_q;
  logic [31:0]       am_rd_q;
  logic [SlopeW-1:0] sl_rd_q;
  logic [31:0]       tr_q;
  logic [53:0]       prod_q;
  logic [32:0]       dmag_q;
  logic [SlopeW-1:0] smag_q;
  logic              mneg_q;
  logic [80:0]       acc_q;
  logic [1:0]        mcnt_q;
  logic [31:0]       res_value_q;
  logic [1:0]        res_status_q;
  logic              out_valid_q;
  logic [31:0]       out_value_q;
  logic [6:0]        out_segment_q;
  logic [1:0]        out_status_q;

  logic [31:0]       times_mem  [MaxPoints];
  logic [31:0]       amps_mem   [MaxPoints];
  logic [SlopeW-1:0] slopes_mem [MaxPoints];

  logic [RndW-1:0]    r_eff;
  logic signed [33:0] rnd_num;
  logic [33:0]        rnd_mag;
  logic signed [54:0] rnd_val;
  logic signed [32:0] dt;
  logic [32:0]        dt_mag;
  logic signed [32:0] da;
  logic [32:0]        da_mag;
  logic               sl_neg;
  logic [DvdW-1:0]    div_dvd;
  logic [DsrW-1:0]    div_dsr;
  logic               div_busy;
  logic [DvdW-1:0]    div_quo;
  logic [SlopeW-1:0]  slope_wr;
  logic               rd_en;
  logic [AddrW-1:0]   raddr;
  logic [AddrW-1:0]   k_addr;
  logic               ptr_mid;
  logic signed [32:0] qd;
  logic [15:0]        chunk;
  logic [48:0]        pp;
  logic [48:0]        cval;
  logic signed [50:0] qsum;
  logic [31:0]        qval;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounding_q   <= RndW'(1);
      num_points_q <= PtrW'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRounding:  rounding_q   <= cfg_data_i[RndW-1:0];
        CfgNumPoints: num_points_q <= cfg_data_i[PtrW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp point count, treat zero granule as one
  assign n_eff = (num_points_q < PtrW'(2)) ? PtrW'(2) :
                 (num_points_q > PtrW'(MaxPoints)) ? PtrW'(MaxPoints) : num_points_q;
  assign r_eff = (rounding_q == '0) ? RndW'(1) : rounding_q;

  // Hold the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_req_type_i;
      p_q   <= in_point_index_i;
      t_q   <= in_time_us_i;
      amp_q <= in_amplitude_i;
    end
  end

  // Rounding: (t + r/2) / r, magnitude form, truncating toward zero
  assign rnd_num = $signed({{2{t_q[31]}}, t_q}) + $signed({14'd0, r_eff[RndW-1:1]});
  assign rnd_mag = rnd_num[33] ? 34'(-rnd_num) : 34'(rnd_num);
  assign rnd_val = rnd_num[33] ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});

  // Slope operands against the previous breakpoint
  assign dt     = $signed({tr_q[31], tr_q}) - $signed({tm_rd_q[31], tm_rd_q});
  assign dt_mag = dt[32] ? 33'(-dt) : 33'(dt);
  assign da     = $signed({amp_q[31], amp_q}) - $signed({am_rd_q[31], am_rd_q});
  assign da_mag = da[32] ? 33'(-da) : 33'(da);
  assign sl_neg = da[32] ^ dt[32];

  assign div_dvd = cmd_i.div_sel ? {da_mag[31:0], 16'd0} : {14'd0, rnd_mag};
  assign div_dsr = cmd_i.div_sel ? dt_mag : {12'd0, r_eff};

  plwg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .quo_o      (div_quo)
  );

  // Saturate slope to 48 bit signed
  always_comb begin
    if (dt == '0) begin
      slope_wr = '0;
    end else if (!sl_neg) begin
      slope_wr = (div_quo > {1'b0, {(SlopeW-1){1'b1}}}) ? {1'b0, {(SlopeW-1){1'b1}}} : div_quo;
    end else begin
      slope_wr = (div_quo > {1'b1, {(SlopeW-1){1'b0}}}) ? {1'b1, {(SlopeW-1){1'b0}}} :
                 SlopeW'(-div_quo);
    end
  end

  // Rounded time: multiply back and clamp to 32 bit
  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd_mul) prod_q <= 54'(div_quo[32:0]) * 54'(r_eff);
    if (cmd_i.rnd_fin) begin
      if (rnd_val > 55'sd2147483647) tr_q <= 32'h7FFF_FFFF;
      else if (rnd_val < -55'sd2147483648) tr_q <= 32'h8000_0000;
      else tr_q <= rnd_val[31:0];
    end
  end

  // Read address: previous point, pointer probe, or segment start
  assign ptr_mid = (seg_ptr_q != '0) && (seg_ptr_q < n_eff);
  always_comb begin
    if (seg_ptr_q == '0) k_addr = '0;
    else if (!ptr_mid) k_addr = AddrW'(n_eff - PtrW'(1));
    else k_addr = AddrW'(seg_ptr_q - PtrW'(1));
  end
  assign rd_en = cmd_i.rd_prev | cmd_i.rd_ptr | cmd_i.rd_k;
  assign raddr = cmd_i.rd_prev ? AddrW'(p_q - AddrW'(1)) :
                 cmd_i.rd_ptr  ? seg_ptr_q[AddrW-1:0] : k_addr;

  // Breakpoint tables
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_commit) begin
      times_mem[p_q] <= tr_q;
      amps_mem[p_q]  <= amp_q;
      if (p_q != '0) slopes_mem[AddrW'(p_q - AddrW'(1))] <= slope_wr;
    end
    if (rd_en) begin
      tm_rd_q <= times_mem[raddr];
      am_rd_q <= amps_mem[raddr];
      sl_rd_q <= slopes_mem[raddr];
    end
  end

  // Segment pointer and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_ptr_q <= '0;
      loaded_q  <= '0;
    end else if (cmd_i.ld_commit) begin
      seg_ptr_q <= '0;
      loaded_q  <= {1'b0, p_q} + PtrW'(1);
    end else if (cmd_i.clamp_ptr) begin
      if (seg_ptr_q > n_eff) seg_ptr_q <= n_eff;
    end else if (cmd_i.ptr_inc) begin
      seg_ptr_q <= seg_ptr_q + PtrW'(1);
    end
  end

  // Elapsed time times slope, 16 slope bits per pass
  assign qd = $signed({t_q[31], t_q}) - $signed({tm_rd_q[31], tm_rd_q});
  always_comb begin
    case (mcnt_q)
      2'd0:    chunk = smag_q[15:0];
      2'd1:    chunk = smag_q[31:16];
      default: chunk = smag_q[47:32];
    endcase
  end
  assign pp = 49'(dmag_q) * 49'(chunk);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_init) begin
      dmag_q <= qd[32] ? 33'(-qd) : 33'(qd);
      smag_q <= sl_rd_q[SlopeW-1] ? SlopeW'(-sl_rd_q) : sl_rd_q;
      mneg_q <= qd[32] ^ sl_rd_q[SlopeW-1];
      acc_q  <= '0;
      mcnt_q <= '0;
    end else if (cmd_i.mul_step) begin
      acc_q  <= acc_q + (81'(pp) << {mcnt_q, 4'd0});
      mcnt_q <= mcnt_q + 2'd1;
    end
  end

  // Add to segment start amplitude and saturate
  assign cval = acc_q[80:32];
  assign qsum = mneg_q ? $signed({{19{am_rd_q[31]}}, am_rd_q}) - $signed({2'b0, cval}) :
                         $signed({{19{am_rd_q[31]}}, am_rd_q}) + $signed({2'b0, cval});
  always_comb begin
    if (qsum > 51'sd2147483647) qval = 32'h7FFF_FFFF;
    else if (qsum < -51'sd2147483648) qval = 32'h8000_0000;
    else qval = qsum[31:0];
  end

  // Result of the current request
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_commit) begin
      res_value_q  <= '0;
      res_status_q <= (p_q != '0 && dt == '0) ? StZeroSeg : StStored;
    end else if (cmd_i.q_fin) begin
      res_value_q  <= ptr_mid ? qval : am_rd_q;
      res_status_q <= StQueryOk;
    end else if (cmd_i.set_reject) begin
      res_value_q  <= '0;
      res_status_q <= StReject;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q   <= res_value_q;
      out_segment_q <= seg_ptr_q;
      out_status_q  <= res_status_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign out_segment_o = out_segment_q;
  assign out_status_o  = out_status_q;

  // Status towards the controller
  assign sts_o.req      = req_q;
  assign sts_o.ld_ok    = ({1'b0, p_q} < n_eff) && (p_q == '0 || {1'b0, p_q} == loaded_q);
  assign sts_o.q_ok     = loaded_q >= n_eff;
  assign sts_o.ptr_lt_n = seg_ptr_q < n_eff;
  assign sts_o.time_lt  = $signed(tm_rd_q) < t_q;
  assign sts_o.ptr_mid  = ptr_mid;
  assign sts_o.dt_zero  = dt == '0;
  assign sts_o.p_zero   = p_q == '0;
  assign sts_o.div_busy = div_busy;
  assign sts_o.mul_last = mcnt_q == 2'd2;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  `PLWG_ASSERT_NXT(a_commit_resets_ptr, clk_i, rst_ni, cmd_i.ld_commit, seg_ptr_q == '0 && loaded_q != '0)
  `PLWG_ASSERT_IMP(a_inc_below_n, clk_i, rst_ni, cmd_i.ptr_inc, seg_ptr_q < n_eff)
  `PLWG_ASSERT_IMP(a_emit_slot_free, clk_i, rst_ni, cmd_i.emit, !out_valid_q || out_ready_i)
  `PLWG_ASSERT_IMP(a_div_idle_start, clk_i, rst_ni, cmd_i.div_start, !div_busy)

endmodule

[hdl/plwg_ctrl.sv]
`timescale 1ns / 1ps
module plwg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  plwg_pkg::sts_t sts_i,
  output plwg_pkg::cmd_t cmd_o
);
  import plwg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_LD_RDIV, S_LD_RMUL, S_LD_DT, S_LD_SDIV,
    S_Q_RD, S_Q_CMP, S_Q_FETCH, S_Q_WAIT, S_Q_MUL, S_Q_FIN, S_DONE
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.req == ReqLoad) begin
          if (sts_i.ld_ok) begin
            cmd_o.div_start = 1'b1;
            cmd_o.rd_prev   = 1'b1;
            state_d         = S_LD_RDIV;
          end else begin
            cmd_o.set_reject = 1'b1;
            state_d          = S_DONE;
          end
        end else if (sts_i.q_ok) begin
          cmd_o.clamp_ptr = 1'b1;
          state_d         = S_Q_RD;
        end else begin
          cmd_o.set_reject = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_LD_RDIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.rnd_mul = 1'b1;
          state_d       = S_LD_RMUL;
        end
      end
      S_LD_RMUL: begin
        cmd_o.rnd_fin = 1'b1;
        state_d       = S_LD_DT;
      end
      S_LD_DT: begin
        if (sts_i.p_zero || sts_i.dt_zero) begin
          cmd_o.ld_commit = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b1;
          state_d         = S_LD_SDIV;
        end
      end
      S_LD_SDIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.ld_commit = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_Q_RD: begin
        if (sts_i.ptr_lt_n) begin
          cmd_o.rd_ptr = 1'b1;
          state_d      = S_Q_CMP;
        end else begin
          state_d = S_Q_FETCH;
        end
      end
      S_Q_CMP: begin
        if (sts_i.time_lt) begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_Q_RD;
        end else begin
          state_d = S_Q_FETCH;
        end
      end
      S_Q_FETCH: begin
        cmd_o.rd_k = 1'b1;
        state_d    = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        if (sts_i.ptr_mid) begin
          cmd_o.mul_init = 1'b1;
          state_d        = S_Q_MUL;
        end else begin
          state_d = S_Q_FIN;
        end
      end
      S_Q_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) state_d = S_Q_FIN;
      end
      S_Q_FIN: begin
        cmd_o.q_fin = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

[hdl/piecewise_linear_waveform_gen_top.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload
// in_if     in   req_type, point_index, time_us, amplitude
// out_if    out  value, segment, status
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One request at a time. A query reads and compares each breakpoint the
// pointer passes and, inside a segment, runs three 33x16 multiplier passes.
// A load runs the serial divider for the rounding, then again for the slope
// unless the point is the first one or its time step is zero.
// The output register lets the next request in while a result waits.
// Reset is asynchronous; the breakpoint tables are not cleared.
module piecewise_linear_waveform_gen_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  plwg_in_if.sink                       in_if,
  plwg_out_if.source                    out_if,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [plwg_pkg::CfgDataW-1:0] cfg_data_i
);
  import plwg_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  plwg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plwg_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_req_type_i    (in_if.req_type),
    .in_point_index_i (in_if.point_index),
    .in_time_us_i     (in_if.time_us),
    .in_amplitude_i   (in_if.amplitude),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (out_if.ready),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_if.valid),
    .out_value_o      (out_if.value),
    .out_segment_o    (out_if.segment),
    .out_status_o     (out_if.status)
  );

  assign in_if.ready = in_ready;

endmodule
